@@ rtl/core/hnbc_pkg.sv @@
`timescale 1ns / 1ps
package hnbc_pkg;

  localparam int MAX_CLASSES  = 16;
  localparam int CLS_W        = 4;
  localparam int MAX_FEATURES = 1024;
  localparam int FEAT_W       = 10;
  localparam int POS_W        = 11;
  localparam int MAX_BINS     = 16;
  localparam int BIN_W        = 4;
  localparam int COUNT_BITS   = 20;
  localparam int ADDR_W       = CLS_W + FEAT_W + BIN_W;
  localparam int MEM_DEPTH    = MAX_CLASSES * MAX_FEATURES * MAX_BINS;

  // log2 unit: argument below 2^30, result k*4096 + frac in Q.12
  localparam int LOG_IN_W = 30;
  localparam int LOG_FRAC = 12;
  localparam int LOG_W    = 17;

  localparam int SCORE_W = 32;
  localparam int TERM_W  = 20;
  localparam logic signed [TERM_W-1:0] LOG_FLOOR = -20'sd136066;

  localparam int W_W   = 31;  // Q30 weight
  localparam int SUM_W = 35;
  localparam int DIV_W = 48;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_N        = 3'd4;

  typedef struct packed {
    logic                start;
    logic [LOG_IN_W-1:0] arg;
  } log_req_t;

  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] value;
  } log_rsp_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
  endfunction

  function automatic logic signed [SCORE_W-1:0] sat_add(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [TERM_W-1:0]  b
  );
    logic signed [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {{(SCORE_W+1-TERM_W){b[TERM_W-1]}}, b};
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      return s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end
    return s[SCORE_W-1:0];
  endfunction

  // 2^(-2^b/4096) in Q30
  function automatic logic [29:0] exp_tbl(input logic [3:0] b);
    logic [29:0] r;
    unique case (b)
      4'd0:    r = 30'd1073560137;
      4'd1:    r = 30'd1073378481;
      4'd2:    r = 30'd1073015261;
      4'd3:    r = 30'd1072289189;
      4'd4:    r = 30'd1070812183;
      4'd5:    r = 30'd1067937712;
      4'd6:    r = 30'd1062175491;
      4'd7:    r = 30'd1050733751;
      4'd8:    r = 30'd1028218693;
      4'd9:    r = 30'd984625594;
      4'd10:   r = 30'd902905651;
      4'd11:   r = 30'd759250125;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/hnbc_log2.sv @@
`timescale 1ns / 1ps
module hnbc_log2 import hnbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  log_req_t req,
  output log_rsp_t rsp
);

  logic            busy;
  logic            done;
  logic [3:0]      step;
  logic [4:0]      k;
  logic [W_W-1:0]  m;
  logic [LOG_FRAC-1:0] r;
  logic [4:0]      msb;
  logic [2*W_W-1:0] sq;
  logic [W_W:0]    t;

  // msb position of the argument
  always_comb begin
    msb = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (req.arg[i]) msb = 5'(i);
    end
  end

  assign sq = {{W_W{1'b0}}, m} * {{W_W{1'b0}}, m};
  assign t  = sq[2*W_W-1:W_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        k    <= msb;
        m    <= W_W'({1'b0, req.arg} << (5'd30 - msb));
        r    <= '0;
      end else if (busy) begin
        // one squaring per cycle yields one fraction bit
        r    <= {r[LOG_FRAC-2:0], t[W_W]};
        m    <= t[W_W] ? t[W_W:1] : t[W_W-1:0];
        step <= step + 1'b1;
        if (step == 4'(LOG_FRAC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = {k, r};

endmodule

@@ rtl/core/histogram_naive_bayes_classifier_unit.sv @@
`timescale 1ns / 1ps
// Streaming histogram naive Bayes classifier, Laplace smoothing.
// Input channel (in_valid/in_stall): one feature per transaction, cmd 0 trains,
//   cmd 1 classifies; last_feature closes the image. in_stall is high while
//   the block works on a transaction, so one transaction is in flight at once.
// Output channel (out_valid/out_stall): top_n ranked transactions after the
//   last classify feature, best first, is_last on the final one. A stalled
//   result holds; the block waits on it before ranking the next class.
// Config channel (cfg_valid/cfg_ready): always ready; write only while idle.
// Steps (a feature past num_features gets bookkeeping only):
//   train feature: bin-count read, write-back (good label only), bookkeeping.
//   classify feature: per class a count read and two passes of the shared
//     log2 unit (numerator, denominator), or a floor term if either is zero.
//   final classify: priors (2 log2 passes per trained class), a max scan, an
//     exp2 per live class, then per result a rank scan and a restoring divide.
// Reset: counts, position and registers go to defaults, then a clearing pass
//   zeroes all 262144 bin-count words; in_stall stays high until it is done.
//   Config writes are taken throughout.
module histogram_naive_bayes_classifier_unit import hnbc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [7:0]            label,
  input  logic signed [17:0]    feature_value,
  input  logic                  last_feature,
  // ranked results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CLS_W-1:0]      class_index,
  output logic [16:0]           probability,
  output logic                  is_last,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_TWR   = 5'd2;   // train write-back
  localparam logic [4:0] S_CRD   = 5'd3;   // classify count read
  localparam logic [4:0] S_NUM   = 5'd4;
  localparam logic [4:0] S_LNUM  = 5'd5;
  localparam logic [4:0] S_LDEN  = 5'd6;
  localparam logic [4:0] S_END   = 5'd7;
  localparam logic [4:0] S_LIVE  = 5'd8;
  localparam logic [4:0] S_PRI   = 5'd9;
  localparam logic [4:0] S_PL1   = 5'd10;
  localparam logic [4:0] S_PL2   = 5'd11;
  localparam logic [4:0] S_MAX   = 5'd12;
  localparam logic [4:0] S_EXP   = 5'd13;
  localparam logic [4:0] S_EXB   = 5'd14;
  localparam logic [4:0] S_EXW   = 5'd15;
  localparam logic [4:0] S_RSC   = 5'd16;
  localparam logic [4:0] S_DVS   = 5'd17;
  localparam logic [4:0] S_DIV   = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0] state;

  // configuration registers
  logic [4:0]  num_classes;
  logic [10:0] num_features;
  logic [4:0]  num_bins;
  logic [15:0] alpha_smoothing;
  logic [4:0]  top_n;

  // limited views
  logic [4:0]       nc_l;
  logic [POS_W-1:0] nf_l;
  logic [4:0]       nb_l;
  logic [4:0]       n_l;

  assign nc_l = (num_classes == '0) ? 5'd1 :
                (num_classes > 5'(MAX_CLASSES)) ? 5'(MAX_CLASSES) : num_classes;
  assign nf_l = (num_features == '0) ? 11'd1 :
                (num_features > 11'(MAX_FEATURES)) ? 11'(MAX_FEATURES) : num_features;
  assign nb_l = (num_bins == '0) ? 5'd1 :
                (num_bins > 5'(MAX_BINS)) ? 5'(MAX_BINS) : num_bins;
  assign n_l  = (top_n == '0) ? 5'd1 : (top_n > nc_l) ? nc_l : top_n;

  // persistent state
  logic [COUNT_BITS-1:0]   cc [MAX_CLASSES];
  logic [COUNT_BITS-1:0]   image_total;
  logic [POS_W-1:0]        pos;
  logic                    label_ok;
  logic signed [SCORE_W-1:0] scores [MAX_CLASSES];

  // bin-count memory
  logic [COUNT_BITS-1:0] bin_mem [MEM_DEPTH];
  logic [COUNT_BITS-1:0] mem_q;
  logic                  mem_we;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic [ADDR_W-1:0]     clr_addr;

  // per-item registers
  logic              cmd_r;
  logic              last_r;
  logic              train_ok;
  logic [BIN_W-1:0]  bin_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CLS_W-1:0]  cls;
  logic [LOG_IN_W-1:0] den_r;
  logic [LOG_W-1:0]  lognum;

  // final-stage registers
  logic                    any_r;
  logic [MAX_CLASSES-1:0]  live;
  logic [MAX_CLASSES-1:0]  used;
  logic                    found;
  logic signed [SCORE_W-1:0] best;
  logic [SCORE_W:0]        e_r;
  logic [W_W-1:0]          em;
  logic [3:0]              eb;
  logic [W_W-1:0]          w [MAX_CLASSES];
  logic [SUM_W-1:0]        sum;
  logic [W_W-1:0]          wp;
  logic [CLS_W-1:0]        pick;
  logic [CLS_W-1:0]        rank;
  logic [DIV_W-1:0]        quo;
  logic [SUM_W-1:0]        rem;
  logic [5:0]              dstep;

  log_req_t log_req;
  log_rsp_t log_rsp;

  hnbc_log2 u_log2 (
    .clk (clk),
    .rst (rst),
    .req (log_req),
    .rsp (log_rsp)
  );

  // ---------------- input side ----------------
  logic             in_acc;
  logic [16:0]      vc;
  logic [21:0]      vprod;
  logic [4:0]       bin_raw;
  logic [BIN_W-1:0] bin_in;
  logic             ok_eff;
  logic             active;
  logic [ADDR_W-1:0] train_addr;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign vc = feature_value[17] ? 17'd0 :
              (feature_value > 18'sd65536) ? 17'd65536 : feature_value[16:0];
  assign vprod   = {5'd0, vc} * {17'd0, nb_l};
  assign bin_raw = vprod[20:16];
  assign bin_in  = (bin_raw >= nb_l) ? BIN_W'(nb_l - 5'd1) : bin_raw[BIN_W-1:0];

  assign ok_eff     = (pos == '0) ? (label < 8'(nc_l)) : label_ok;
  assign active     = pos < nf_l;
  assign train_addr = {label[CLS_W-1:0], pos[FEAT_W-1:0], bin_in};

  // ---------------- datapath pieces ----------------
  logic [LOG_IN_W-1:0] num_c;
  logic [LOG_IN_W-1:0] den_c;
  logic [20:0]         alpha_nb;
  logic signed [TERM_W-1:0] log_diff;
  logic                last_cls;

  assign alpha_nb = {5'd0, alpha_smoothing} * {16'd0, nb_l};
  assign num_c    = LOG_IN_W'({mem_q, 8'd0}) + LOG_IN_W'(alpha_smoothing);
  assign den_c    = LOG_IN_W'({cc[cls], 8'd0}) + LOG_IN_W'(alpha_nb);
  assign log_diff = TERM_W'({3'd0, lognum}) - TERM_W'({3'd0, log_rsp.value});
  assign last_cls = (5'(cls) + 5'd1) >= nc_l;

  // exp2 step: multiply by table constant with rounding
  logic [60:0] ex_prod;
  logic [W_W-1:0] w_val;
  assign ex_prod = {30'd0, em} * {31'd0, exp_tbl(eb)} + 61'(1 << 29);
  assign w_val   = (e_r[SCORE_W:LOG_FRAC] >= 21'd31) ? '0 : (em >> e_r[LOG_FRAC+4:LOG_FRAC]);

  // restoring divide step
  logic [SUM_W:0]   rem_sh;
  logic             q_bit;
  logic [SUM_W:0]   rem_n;
  logic [DIV_W-1:0] quo_n;
  assign rem_sh = {rem, quo[DIV_W-1]};
  assign q_bit  = rem_sh >= {1'b0, sum};
  assign rem_n  = q_bit ? (rem_sh - {1'b0, sum}) : rem_sh;
  assign quo_n  = {quo[DIV_W-2:0], q_bit};

  // live classes at the end of a classify image
  logic [MAX_CLASSES-1:0] live_raw;
  logic [MAX_CLASSES-1:0] in_use;
  always_comb begin
    for (int c = 0; c < MAX_CLASSES; c++) begin
      in_use[c]   = 5'(c) < nc_l;
      live_raw[c] = in_use[c] && (image_total != '0) && (cc[c] != '0);
    end
  end

  // ---------------- log2 requests ----------------
  always_comb begin
    log_req.start = 1'b0;
    log_req.arg   = num_c;
    unique case (state)
      S_NUM: begin
        log_req.start = (num_c != '0) && (den_c != '0);
        log_req.arg   = num_c;
      end
      S_LNUM: begin
        log_req.start = log_rsp.done;
        log_req.arg   = den_r;
      end
      S_PRI: begin
        log_req.start = any_r && live[cls];
        log_req.arg   = LOG_IN_W'(cc[cls]);
      end
      S_PL1: begin
        log_req.start = log_rsp.done;
        log_req.arg   = LOG_IN_W'(image_total);
      end
      default: ;
    endcase
  end

  // ---------------- memory ----------------
  assign mem_we    = (state == S_CLEAR) || (state == S_TWR);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : addr_r;
  assign mem_wdata = (state == S_CLEAR) ? '0 : sat_inc(mem_q);
  assign mem_re    = (in_acc && active && !cmd && ok_eff && (label < 8'(nc_l)))
                     || (state == S_CRD);
  assign mem_raddr = (state == S_IDLE) ? train_addr : {cls, pos[FEAT_W-1:0], bin_r};

  always_ff @(posedge clk) begin
    if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= bin_mem[mem_raddr];
  end

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes     <= 5'd10;
      num_features    <= 11'd1024;
      num_bins        <= 5'd16;
      alpha_smoothing <= 16'd256;
      top_n           <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_CLASSES:  num_classes     <= cfg_data[4:0];
        CFG_NUM_FEATURES: num_features    <= cfg_data[10:0];
        CFG_NUM_BINS:     num_bins        <= cfg_data[4:0];
        CFG_ALPHA:        alpha_smoothing <= cfg_data;
        CFG_TOP_N:        top_n           <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      pos         <= '0;
      label_ok    <= 1'b0;
      image_total <= '0;
      for (int c = 0; c < MAX_CLASSES; c++) cc[c] <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= S_IDLE;
        end

        S_IDLE: begin
          if (in_acc) begin
            cmd_r    <= cmd;
            last_r   <= last_feature;
            train_ok <= ok_eff && (label < 8'(nc_l));
            bin_r    <= bin_in;
            addr_r   <= train_addr;
            cls      <= cmd ? '0 : label[CLS_W-1:0];
            if (pos == '0) begin
              label_ok <= label < 8'(nc_l);
              for (int c = 0; c < MAX_CLASSES; c++) scores[c] <= '0;
            end
            if (mem_re)              state <= S_TWR;
            else if (active && cmd)  state <= S_CRD;
            else                     state <= S_END;
          end
        end

        S_TWR: state <= S_END;

        S_CRD: state <= S_NUM;

        S_NUM: begin
          den_r <= den_c;
          if (log_req.start) begin
            state <= S_LNUM;
          end else begin
            // zero smoothing with an empty count: floor term
            scores[cls] <= sat_add(scores[cls], LOG_FLOOR);
            if (last_cls) state <= S_END;
            else begin
              cls   <= cls + 1'b1;
              state <= S_CRD;
            end
          end
        end

        S_LNUM: begin
          if (log_rsp.done) begin
            lognum <= log_rsp.value;
            state  <= S_LDEN;
          end
        end

        S_LDEN: begin
          if (log_rsp.done) begin
            scores[cls] <= sat_add(scores[cls], log_diff);
            if (last_cls) state <= S_END;
            else begin
              cls   <= cls + 1'b1;
              state <= S_CRD;
            end
          end
        end

        S_END: begin
          if (!last_r) begin
            if (pos < nf_l) pos <= pos + 1'b1;
            state <= S_IDLE;
          end else begin
            pos <= '0;
            if (!cmd_r) begin
              if (train_ok) cc[cls] <= sat_inc(cc[cls]);
              image_total <= sat_inc(image_total);
              state <= S_IDLE;
            end else begin
              state <= S_LIVE;
            end
          end
        end

        S_LIVE: begin
          any_r <= |live_raw;
          live  <= (|live_raw) ? live_raw : in_use;
          cls   <= '0;
          state <= S_PRI;
        end

        S_PRI: begin
          if (log_req.start) state <= S_PL1;
          else if (last_cls) begin
            cls   <= '0;
            found <= 1'b0;
            state <= S_MAX;
          end else cls <= cls + 1'b1;
        end

        S_PL1: begin
          if (log_rsp.done) begin
            lognum <= log_rsp.value;
            state  <= S_PL2;
          end
        end

        S_PL2: begin
          if (log_rsp.done) begin
            scores[cls] <= sat_add(scores[cls], log_diff);
            if (last_cls) begin
              cls   <= '0;
              found <= 1'b0;
              state <= S_MAX;
            end else begin
              cls   <= cls + 1'b1;
              state <= S_PRI;
            end
          end
        end

        S_MAX: begin
          if (live[cls] && (!found || scores[cls] > best)) begin
            best  <= scores[cls];
            found <= 1'b1;
          end
          if (last_cls) begin
            cls   <= '0;
            sum   <= '0;
            state <= S_EXP;
          end else cls <= cls + 1'b1;
        end

        S_EXP: begin
          if (live[cls]) begin
            e_r   <= {best[SCORE_W-1], best} - {scores[cls][SCORE_W-1], scores[cls]};
            em    <= W_W'(1 << 30);
            eb    <= '0;
            state <= S_EXB;
          end else begin
            w[cls] <= '0;
            if (last_cls) begin
              cls   <= '0;
              rank  <= '0;
              used  <= '0;
              found <= 1'b0;
              state <= S_RSC;
            end else cls <= cls + 1'b1;
          end
        end

        S_EXB: begin
          if (e_r[eb]) em <= ex_prod[60:30];
          eb <= eb + 1'b1;
          if (eb == 4'(LOG_FRAC - 1)) state <= S_EXW;
        end

        S_EXW: begin
          w[cls] <= w_val;
          sum    <= sum + SUM_W'(w_val);
          if (last_cls) begin
            cls   <= '0;
            rank  <= '0;
            used  <= '0;
            found <= 1'b0;
            state <= S_RSC;
          end else begin
            cls   <= cls + 1'b1;
            state <= S_EXP;
          end
        end

        S_RSC: begin
          // strict compare keeps the lower index on ties
          if (!used[cls] && (!found || w[cls] > wp)) begin
            pick  <= cls;
            wp    <= w[cls];
            found <= 1'b1;
          end
          if (last_cls) state <= S_DVS;
          else cls <= cls + 1'b1;
        end

        S_DVS: begin
          used[pick] <= 1'b1;
          quo   <= DIV_W'({wp, 16'd0}) + DIV_W'(sum >> 1);
          rem   <= '0;
          dstep <= '0;
          state <= S_DIV;
        end

        S_DIV: begin
          quo   <= quo_n;
          rem   <= rem_n[SUM_W-1:0];
          dstep <= dstep + 1'b1;
          if (dstep == 6'(DIV_W - 1)) begin
            class_index <= pick;
            probability <= quo_n[16:0];
            is_last     <= (5'(rank) + 5'd1) == n_l;
            state       <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_stall) begin
            if (is_last) state <= S_IDLE;
            else begin
              rank  <= rank + 1'b1;
              cls   <= '0;
              found <= 1'b0;
              state <= S_RSC;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/tb_histogram_naive_bayes_classifier_unit.sv @@
`timescale 1ns / 1ps
module tb_histogram_naive_bayes_classifier_unit;
  import hnbc_pkg::*;

  localparam logic CMD_TRAIN    = 1'b0;
  localparam logic CMD_CLASSIFY = 1'b1;
  localparam int   LOG_FLOOR_Q12 = -136066;
  localparam int   IDLE_WAIT = 800;  // longer than a classify feature with 16 classes

  typedef struct {
    logic [3:0]  cls;
    logic [16:0] prob;
    logic        last;
  } ranked_t;

  // Scoreboard: keeps a private copy of the classifier state, follows every
  // accepted feature, predicts the ranked transactions and checks them in order.
  class nb_scoreboard;
    int unsigned bins_hist[MAX_CLASSES*MAX_FEATURES*MAX_BINS];
    int unsigned class_imgs[MAX_CLASSES];
    int unsigned img_total;
    int unsigned feat_pos;
    int          score[MAX_CLASSES];
    bit          label_ok;
    int unsigned reg_nc, reg_nf, reg_nb, reg_alpha, reg_topn;
    ranked_t     ranked_q[$];
    int          errors;
    int          checked;

    function new();
      foreach (bins_hist[i]) bins_hist[i] = 0;
      foreach (class_imgs[i]) class_imgs[i] = 0;
      foreach (score[i]) score[i] = 0;
      img_total = 0; feat_pos = 0; label_ok = 0;
      reg_nc = 10; reg_nf = 1024; reg_nb = 16; reg_alpha = 256; reg_topn = 1;
      errors = 0; checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_NUM_CLASSES:  reg_nc    = d & 16'h1F;
        CFG_NUM_FEATURES: reg_nf    = d & 16'h7FF;
        CFG_NUM_BINS:     reg_nb    = d & 16'h1F;
        CFG_ALPHA:        reg_alpha = d;
        CFG_TOP_N:        reg_topn  = d & 16'h1F;
        default: ;
      endcase
    endfunction

    function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function int unsigned bump(int unsigned v);
      return v < 32'hFFFFF ? v + 1 : 32'hFFFFF;
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
    endfunction

    // log2 in Q.12: msb position plus 12 squaring steps on a Q30 mantissa
    function longint log2_q12(longint unsigned x);
      int k;
      longint unsigned m;
      longint r;
      k = 63; r = 0;
      while (k > 0 && x[k] == 1'b0) k--;
      m = (k >= 30) ? (x >> (k - 30)) : (x << (30 - k));
      for (int i = 0; i < LOG_FRAC; i++) begin
        m = (m * m) >> 30;
        r = r << 1;
        if (m >= (64'd1 << 31)) begin
          r = r | 1;
          m = m >> 1;
        end
      end
      return longint'(k) * 4096 + r;
    endfunction

    // 2^(-e/4096) in Q30
    function longint unsigned weight_q30(longint unsigned e);
      longint unsigned ip, m;
      ip = e >> LOG_FRAC;
      m  = 64'd1 << 30;
      for (int b = 0; b < LOG_FRAC; b++)
        if (e[b]) m = (m * exp_tbl(4'(b)) + (64'd1 << 29)) >> 30;
      return ip >= 31 ? 0 : (m >> ip);
    endfunction

    function void note_feature(logic c, logic [7:0] lbl, logic signed [17:0] fv, logic lastf);
      int unsigned nc, nf, nb, bin, f, n, pick, idx;
      longint v, t, best;
      longint unsigned num, den, sum;
      longint unsigned w[MAX_CLASSES];
      bit live[MAX_CLASSES];
      bit used[MAX_CLASSES];
      bit any, found;
      ranked_t r;
      nc = clip(reg_nc, 1, MAX_CLASSES);
      nf = clip(reg_nf, 1, MAX_FEATURES);
      nb = clip(reg_nb, 1, MAX_BINS);
      if (feat_pos == 0) begin
        label_ok = lbl < nc;
        foreach (score[i]) score[i] = 0;
      end
      v = fv;
      if (v < 0) v = 0;
      if (v > 65536) v = 65536;
      bin = (v * nb) >> 16;
      if (bin >= nb) bin = nb - 1;
      f = feat_pos;
      if (f < nf) begin
        if (c == CMD_TRAIN) begin
          if (label_ok && lbl < nc) begin
            idx = (lbl * MAX_FEATURES + f) * MAX_BINS + bin;
            bins_hist[idx] = bump(bins_hist[idx]);
          end
        end else begin
          for (int k = 0; k < nc; k++) begin
            num = longint'(bins_hist[(k * MAX_FEATURES + f) * MAX_BINS + bin]) * 256 + reg_alpha;
            den = longint'(class_imgs[k]) * 256 + longint'(reg_alpha) * nb;
            t = LOG_FLOOR_Q12;
            if (num != 0 && den != 0) begin
              t = log2_q12(num) - log2_q12(den);
              if (t < LOG_FLOOR_Q12) t = LOG_FLOOR_Q12;
            end
            score[k] = sat32(longint'(score[k]) + t);
          end
        end
      end
      if (!lastf) begin
        if (feat_pos < nf) feat_pos++;
        return;
      end
      feat_pos = 0;
      if (c == CMD_TRAIN) begin
        if (label_ok && lbl < nc) class_imgs[lbl] = bump(class_imgs[lbl]);
        img_total = bump(img_total);
        return;
      end
      // final classify: priors, exp2 weights, normalize, rank
      any = 0;
      for (int k = 0; k < nc; k++) begin
        live[k] = img_total != 0 && class_imgs[k] != 0;
        if (live[k]) any = 1;
      end
      for (int k = 0; k < nc; k++) begin
        if (!any) live[k] = 1;
        else if (live[k])
          score[k] = sat32(longint'(score[k]) + log2_q12(class_imgs[k]) - log2_q12(img_total));
      end
      any = 0; best = 0; sum = 0;
      for (int k = 0; k < nc; k++)
        if (live[k] && (!any || score[k] > best)) begin
          best = score[k];
          any = 1;
        end
      for (int k = 0; k < nc; k++) begin
        w[k] = live[k] ? weight_q30(longint'(best - score[k])) : 0;
        sum += w[k];
        used[k] = 0;
      end
      n = clip(reg_topn, 1, nc);
      for (int q = 0; q < n; q++) begin
        pick = 0; found = 0;
        for (int k = 0; k < nc; k++)
          if (!used[k] && (!found || w[k] > w[pick])) begin
            pick = k;
            found = 1;
          end
        used[pick] = 1;
        r.cls  = pick[3:0];
        r.prob = 17'((w[pick] * 65536 + sum / 2) / sum);
        r.last = (q + 1 == n);
        ranked_q.push_back(r);
      end
    endfunction

    function void check_result(logic [3:0] cls, logic [16:0] prob, logic lst);
      ranked_t e;
      if (ranked_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result class %0d prob %0d last %0d", $time, cls, prob, lst);
        return;
      end
      e = ranked_q.pop_front();
      checked++;
      if (cls !== e.cls) begin
        errors++;
        $display("%0t: class_index exp %0d got %0d", $time, e.cls, cls);
      end
      if (prob !== e.prob) begin
        errors++;
        $display("%0t: probability exp %0d got %0d", $time, e.prob, prob);
      end
      if (lst !== e.last) begin
        errors++;
        $display("%0t: is_last exp %0d got %0d", $time, e.last, lst);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  cmd = CMD_TRAIN;
  logic [7:0]            label = '0;
  logic signed [17:0]    feature_value = '0;
  logic                  last_feature = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CLS_W-1:0]      class_index;
  logic [16:0]           probability;
  logic                  is_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  nb_scoreboard sb = new();
  bit calm = 0;          // no idling in the closing stretch
  int features_sent = 0;
  int settings_run = 0;
  int stall_left = 0;

  always #5 clk = ~clk;

  histogram_naive_bayes_classifier_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .label(label),
    .feature_value(feature_value), .last_feature(last_feature),
    .out_valid(out_valid), .out_stall(out_stall), .class_index(class_index),
    .probability(probability), .is_last(is_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // result side: random stall bursts, check every accepted transaction
  always @(posedge clk) begin
    if (out_valid && !out_stall) sb.check_result(class_index, probability, is_last);
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one feature transaction; valid stays high into the next call
  task automatic send_feature(logic c, logic [7:0] lbl, logic signed [17:0] fv, logic lastf);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    label         <= lbl;
    feature_value <= fv;
    last_feature  <= lastf;
    do @(posedge clk); while (in_stall);
    sb.note_feature(c, lbl, fv, lastf);
    features_sent++;
  endtask

  // let every expected ranking arrive, then let the block settle
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.ranked_q.size() != 0 && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  task automatic apply_setting(int nc, int nf, int nb, int alpha, int topn);
    drain();
    write_reg(CFG_NUM_CLASSES, CFG_DATA_W'(nc));
    write_reg(CFG_NUM_FEATURES, CFG_DATA_W'(nf));
    write_reg(CFG_NUM_BINS, CFG_DATA_W'(nb));
    write_reg(CFG_ALPHA, CFG_DATA_W'(alpha));
    write_reg(CFG_TOP_N, CFG_DATA_W'(topn));
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  function automatic logic signed [17:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return $urandom;                       // anything, negatives too
      1:       return $urandom_range(0, 1) ? 18'sd65536 : 18'sd0;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // one image: mostly well-formed train/classify, some noise
  task automatic send_image(int len);
    int nc;
    logic c;
    logic [7:0] lbl;
    bit noisy;
    nc    = sb.reg_nc < 1 ? 1 : (sb.reg_nc > 16 ? 16 : sb.reg_nc);
    noisy = $urandom_range(0, 6) == 0;
    c     = $urandom_range(0, 2) == 0 ? CMD_CLASSIFY : CMD_TRAIN;
    lbl   = $urandom_range(0, nc - 1);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        c   = $urandom_range(0, 1);
        lbl = $urandom;
      end
      send_feature(c, lbl, pick_value(), i == len - 1);
    end
  endtask

  task automatic random_images(int items);
    int start;
    start = features_sent;
    while (features_sent - start < items) send_image($urandom_range(1, 6));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: classify with no training at all (every class empty, no prior)
    send_feature(CMD_CLASSIFY, 8'd0, -18'sd131072, 1'b0);
    send_feature(CMD_CLASSIFY, 8'd0, 18'sd131071, 1'b1);
    // train a few images, value extremes and bin edges
    send_feature(CMD_TRAIN, 8'd3, 18'sd0, 1'b0);
    send_feature(CMD_TRAIN, 8'd3, 18'sd65535, 1'b0);
    send_feature(CMD_TRAIN, 8'd3, 18'sd65536, 1'b1);
    send_feature(CMD_TRAIN, 8'd9, 18'sd32768, 1'b0);
    send_feature(CMD_TRAIN, 8'd9, 18'sd4096, 1'b1);
    // bad labels: out of range latched, and valid latch with a bad later label
    send_feature(CMD_TRAIN, 8'd255, 18'sd100, 1'b0);
    send_feature(CMD_TRAIN, 8'd10, 18'sd100, 1'b1);
    send_feature(CMD_TRAIN, 8'd0, 18'sd100, 1'b0);
    send_feature(CMD_TRAIN, 8'd200, 18'sd100, 1'b1);
    // mixed commands within one image, ending as a classify
    send_feature(CMD_TRAIN, 8'd3, 18'sd0, 1'b0);
    send_feature(CMD_CLASSIFY, 8'd3, 18'sd65535, 1'b0);
    send_feature(CMD_CLASSIFY, 8'd3, 18'sd65536, 1'b1);
    // hold off until the ranking is out
    drain();

    // Top_n all, zero smoothing (floor terms), short images with extra features
    apply_setting(16, 2, 16, 0, 16);
    send_feature(CMD_TRAIN, 8'd15, 18'sd65536, 1'b0);
    send_feature(CMD_TRAIN, 8'd15, 18'sd0, 1'b0);
    send_feature(CMD_TRAIN, 8'd15, 18'sd12345, 1'b1);   // beyond num_features
    send_feature(CMD_CLASSIFY, 8'd0, 18'sd65536, 1'b0);
    send_feature(CMD_CLASSIFY, 8'd0, 18'sd0, 1'b0);
    send_feature(CMD_CLASSIFY, 8'd0, -18'sd5, 1'b1);
    random_images(15);

    // Out-of-range registers, all limited to their bounds, then two in-range settings
    apply_setting(0, 0, 0, 65535, 0);
    random_images(10);
    apply_setting(31, 2047, 31, 1, 31);
    random_images(15);
    apply_setting(5, 3, 7, 128, 3);
    random_images(15);
    apply_setting(2, 1024, 1, 300, 2);
    random_images(10);

    // closing stretch without idling on either side
    apply_setting(16, 4, 16, 256, 5);
    calm = 1;
    random_images(15);

    drain();
    if (sb.ranked_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d rankings never arrived", $time, sb.ranked_q.size());
    end
    $display("covered %0d feature transactions over %0d register settings,", features_sent,
             settings_run + 1);
    $display("%0d ranked results checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_histogram_naive_bayes_classifier_unit: PASS");
    end else begin
      $display("tb_histogram_naive_bayes_classifier_unit: FAIL");
    end
    $finish;
  end

  // watchdog: clearing pass (~2.6 ms) plus a slow run, several times over
  initial begin
    #40ms;
    $display("tb_histogram_naive_bayes_classifier_unit: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/hnbc_pkg.sv
rtl/core/hnbc_log2.sv
rtl/core/histogram_naive_bayes_classifier_unit.sv
tb/sv/tb_histogram_naive_bayes_classifier_unit.sv
